[sv/cpsa_pkg.sv]
// Shared types, constants and helpers for the curve point and slope angle core.
`timescale 1ns / 1ps
package cpsa_pkg;

    // Curve kinds.
    localparam logic [1:0] KIND_LINEAR = 2'd0;
    localparam logic [1:0] KIND_QUAD   = 2'd1;
    localparam logic [1:0] KIND_CUBIC  = 2'd2;
    localparam logic [1:0] KIND_SINE   = 2'd3;

    // Configuration register indexes.
    localparam int          CFG_IDX_W      = 3;
    localparam logic [2:0] REG_CURVE_KIND = 3'd0;
    localparam logic [2:0] REG_COEF_THREE = 3'd1;
    localparam logic [2:0] REG_COEF_TWO   = 3'd2;
    localparam logic [2:0] REG_COEF_ONE   = 3'd3;
    localparam logic [2:0] REG_COEF_ZERO  = 3'd4;

    // Datapath widths: angle, sin/cos datapath, heading vector datapath.
    localparam int Z_W  = 34;
    localparam int SC_W = 34;
    localparam int HV_W = 48;

    localparam logic [63:0] PHASE_K         = 64'h28BE60DB9391054A;
    localparam logic [30:0] HALF_PI_Q30     = 31'h6487ED51;
    localparam logic signed [SC_W-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [30:0] DEG_PER_RAD_Q24  = 31'sd961263669;
    localparam logic signed [26:0] DEG90_Q16        = 27'sd5898240;

    // atan(2^-i) in Q30 radians.
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [1:0]         quad;
        logic               flag;
        logic signed [31:0] slope;
        logic signed [31:0] y;
    } t_rot_side;

    typedef struct packed {
        logic               flag;
        logic signed [31:0] y;
    } t_vec_side;

    // Clamp to the 32-bit signed range; the top bit of the result is the clamp flag.
    function automatic logic [32:0] sat32(input logic signed [69:0] v);
        logic [32:0] res;
        if (v > 70'sd2147483647) begin
            res = {1'b1, 32'h7FFFFFFF};
        end else if (v < -70'sd2147483648) begin
            res = {1'b1, 32'h80000000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

endpackage

[sv/cpsa_cordic.sv]
// Pipelined CORDIC, one micro-rotation per register stage, rotation or vectoring mode.
`timescale 1ns / 1ps
module cpsa_cordic #(
    parameter int STEPS     = 16,
    parameter int W         = 34,
    parameter int SW        = 1,
    parameter bit VECTORING = 1'b0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [W-1:0]            i_x,
    input  logic signed [W-1:0]            i_y,
    input  logic signed [cpsa_pkg::Z_W-1:0] i_z,
    input  logic [SW-1:0]                  i_side,
    output logic                           o_valid,
    output logic signed [W-1:0]            o_x,
    output logic signed [W-1:0]            o_y,
    output logic signed [cpsa_pkg::Z_W-1:0] o_z,
    output logic [SW-1:0]                  o_side
);
    import cpsa_pkg::*;

    logic                  r_v    [STEPS];
    logic signed [W-1:0]   r_x    [STEPS];
    logic signed [W-1:0]   r_y    [STEPS];
    logic signed [Z_W-1:0] r_z    [STEPS];
    logic [SW-1:0]         r_side [STEPS];

    genvar i;
    generate
        for (i = 0; i < STEPS; i++) begin : g_step
            logic                  w_vin;
            logic signed [W-1:0]   w_xin, w_yin, w_dx, w_dy;
            logic signed [Z_W-1:0] w_zin, w_ang;
            logic [SW-1:0]         w_sin;
            logic                  w_up;

            if (i == 0) begin : g_first
                assign w_vin = i_valid;
                assign w_xin = i_x;
                assign w_yin = i_y;
                assign w_zin = i_z;
                assign w_sin = i_side;
            end else begin : g_next
                assign w_vin = r_v[i-1];
                assign w_xin = r_x[i-1];
                assign w_yin = r_y[i-1];
                assign w_zin = r_z[i-1];
                assign w_sin = r_side[i-1];
            end

            assign w_dx  = w_yin >>> i;
            assign w_dy  = w_xin >>> i;
            assign w_ang = $signed({{(Z_W-32){1'b0}}, ATAN_TAB[i]});
            // Rotation drives z toward zero, vectoring drives y toward zero.
            assign w_up  = VECTORING ? (w_yin < 0) : (w_zin >= 0);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[i] <= 1'b0;
                end else if (i_en) begin
                    r_v[i] <= w_vin;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side[i] <= w_sin;
                    if (w_up) begin
                        r_x[i] <= w_xin - w_dx;
                        r_y[i] <= w_yin + w_dy;
                        r_z[i] <= w_zin - w_ang;
                    end else begin
                        r_x[i] <= w_xin + w_dx;
                        r_y[i] <= w_yin - w_dy;
                        r_z[i] <= w_zin + w_ang;
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_v[STEPS-1];
    assign o_x     = r_x[STEPS-1];
    assign o_y     = r_y[STEPS-1];
    assign o_z     = r_z[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

[sv/curve_point_and_slope_angle_core.sv]
// Top level of the curve point and slope angle core.
`timescale 1ns / 1ps
// Evaluates a configured curve at one signed Q16.16 x per transfer and returns the
// value y, the heading atan(dy/dx) in Q8.16 degrees and a saturation flag.
// Curves: linear, quadratic, cubic (Horner form) and a*sin(b*(x-c))+d.
// Input channel: i_in_valid / o_in_stall with i_x_position. Output channel:
// o_out_valid / i_out_stall with o_y_value, o_heading_degrees, o_saturated.
// Configuration: i_cfg_valid / o_cfg_ready, register index and 32-bit data; the
// port is always ready. Write it only while no item is in flight.
// Throughput is one item per cycle unless the output stalls. The pipeline is
// six polynomial/phase stages, the sin/cos CORDIC, five scaling
// stages, the atan CORDIC, the degree multiply and the output register.
// Reset clears all valid bits and the configuration registers to zero.
// While the output holds a result that the receiver stalls, the whole pipeline
// freezes and o_in_stall is raised; nothing is lost or repeated.
module curve_point_and_slope_angle_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [31:0]                i_x_position,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [31:0]                o_y_value,
    output logic signed [23:0]                o_heading_degrees,
    output logic                              o_saturated,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cpsa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);
    import cpsa_pkg::*;

    logic               w_en;
    logic [1:0]         r_kind;
    logic signed [31:0] r_c3, r_c2, r_c1, r_c0;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_LINEAR;
            r_c3   <= '0;
            r_c2   <= '0;
            r_c1   <= '0;
            r_c0   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_CURVE_KIND: r_kind <= i_cfg_data[1:0];
                REG_COEF_THREE: r_c3   <= $signed(i_cfg_data);
                REG_COEF_TWO:   r_c2   <= $signed(i_cfg_data);
                REG_COEF_ONE:   r_c1   <= $signed(i_cfg_data);
                REG_COEF_ZERO:  r_c0   <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless a finished result is held by the receiver.
    logic r_out_v;
    assign w_en       = !(r_out_v && i_out_stall);
    assign o_in_stall = !w_en;

    // Stage 1: leading product and sinusoid offset.
    logic               r1_v;
    logic signed [31:0] r1_x, w1_lead;
    logic signed [63:0] r1_p1;
    logic signed [32:0] r1_d;

    always_comb begin
        unique case (r_kind)
            KIND_LINEAR: w1_lead = r_c1;
            KIND_QUAD:   w1_lead = r_c2;
            KIND_CUBIC:  w1_lead = r_c3;
            KIND_SINE:   w1_lead = r_c3;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x  <= i_x_position;
            r1_p1 <= w1_lead * i_x_position;
            r1_d  <= 33'(i_x_position) - 33'(r_c1);
        end
    end

    // Stage 2: first Horner step and slope seed; sinusoid argument product.
    logic               r2_v, r2_f;
    logic signed [31:0] r2_x, r2_h, r2_s;
    logic signed [63:0] r2_p, w2_a1;
    logic signed [31:0] w2_next, w2_h, w2_seed;
    logic               w2_hf, w2_sf;

    always_comb begin
        w2_a1 = r1_p1 >>> 16;
        unique case (r_kind)
            KIND_LINEAR: begin
                w2_next         = r_c0;
                {w2_sf, w2_seed} = {1'b0, r_c1};
            end
            KIND_QUAD: begin
                w2_next         = r_c1;
                {w2_sf, w2_seed} = sat32(70'sd2 * 70'(w2_a1) + 70'(r_c1));
            end
            KIND_CUBIC: begin
                w2_next         = r_c2;
                {w2_sf, w2_seed} = sat32(70'sd3 * 70'(w2_a1) + 70'sd2 * 70'(r_c2));
            end
            KIND_SINE: begin
                w2_next         = r_c0;
                {w2_sf, w2_seed} = {1'b0, r_c1};
            end
        endcase
        {w2_hf, w2_h} = sat32(70'(w2_a1) + 70'(w2_next));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_x <= r1_x;
            r2_h <= w2_h;
            r2_s <= w2_seed;
            r2_f <= w2_hf | w2_sf;
            r2_p <= r_c2 * r1_d;
        end
    end

    // Stage 3: products with x; partial products of the phase multiply.
    logic               r3_v, r3_f, r3_neg;
    logic signed [31:0] r3_x, r3_h, r3_s;
    logic signed [63:0] r3_q1, r3_q2;
    logic [63:0]        r3_pp00, r3_pp01, r3_pp10, r3_pp11;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_x    <= r2_x;
            r3_h    <= r2_h;
            r3_s    <= r2_s;
            r3_f    <= r2_f;
            r3_q1   <= r2_h * r2_x;
            r3_q2   <= r2_s * r2_x;
            r3_pp00 <= r2_p[31:0]  * PHASE_K[31:0];
            r3_pp01 <= r2_p[31:0]  * PHASE_K[63:32];
            r3_pp10 <= r2_p[63:32] * PHASE_K[31:0];
            r3_pp11 <= r2_p[63:32] * PHASE_K[63:32];
            r3_neg  <= r2_p[63];
        end
    end

    // Stage 4: second Horner step, cubic slope; phase sum.
    logic               r4_v, r4_f;
    logic signed [31:0] r4_x, r4_h, r4_s;
    logic [31:0]        r4_phase;
    logic signed [63:0] w4_q1, w4_q2;
    logic signed [31:0] w4_h, w4_s, w4_t;
    logic               w4_f, w4_hf, w4_sf;
    logic [31:0]        w4_top;
    logic [95:0]        w4_sum;

    always_comb begin
        w4_q1 = r3_q1 >>> 16;
        w4_q2 = r3_q2 >>> 16;
        {w4_hf, w4_t} = sat32(70'(w4_q1) + 70'((r_kind == KIND_CUBIC) ? r_c1 : r_c0));
        {w4_sf, w4_s} = {1'b0, r3_s};
        w4_h = r3_h;
        w4_f = r3_f;
        unique case (r_kind)
            KIND_LINEAR: ;
            KIND_QUAD: begin
                w4_h = w4_t;
                w4_f = r3_f | w4_hf;
            end
            KIND_CUBIC: begin
                w4_h          = w4_t;
                {w4_sf, w4_s} = sat32(70'(w4_q2) + 70'(r_c1));
                w4_f          = r3_f | w4_hf | w4_sf;
            end
            KIND_SINE: ;
        endcase
        // A negative argument contributes -K to the top word of the product.
        w4_top = r3_pp11[31:0] - (r3_neg ? PHASE_K[31:0] : 32'd0);
        w4_sum = 96'(r3_pp00) + {r3_pp01, 32'd0} + {r3_pp10, 32'd0} + {w4_top, 64'd0};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_x     <= r3_x;
            r4_h     <= w4_h;
            r4_s     <= w4_s;
            r4_f     <= w4_f;
            r4_phase <= w4_sum[95:64];
        end
    end

    // Stage 5: third cubic product; phase to CORDIC angle.
    logic               r5_v, r5_f;
    logic signed [31:0] r5_h, r5_s;
    logic signed [63:0] r5_q3;
    logic signed [Z_W-1:0] r5_z;
    logic [1:0]         r5_quad;
    logic [60:0]        w5_zprod;

    assign w5_zprod = r4_phase[29:0] * HALF_PI_Q30;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_h    <= r4_h;
            r5_s    <= r4_s;
            r5_f    <= r4_f;
            r5_q3   <= r4_h * r4_x;
            r5_z    <= $signed({3'b000, w5_zprod[60:30]});
            r5_quad <= r4_phase[31:30];
        end
    end

    // Stage 6: last cubic Horner step.
    logic               r6_v, r6_f;
    logic signed [31:0] r6_y, r6_s;
    logic signed [Z_W-1:0] r6_z;
    logic [1:0]         r6_quad;
    logic signed [31:0] w6_y;
    logic               w6_yf;

    always_comb begin
        {w6_yf, w6_y} = sat32(70'(r5_q3 >>> 16) + 70'(r_c0));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_y    <= (r_kind == KIND_CUBIC) ? w6_y : r5_h;
            r6_f    <= (r_kind == KIND_CUBIC) ? (r5_f | w6_yf) : r5_f;
            r6_s    <= r5_s;
            r6_z    <= r5_z;
            r6_quad <= r5_quad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // sin/cos CORDIC; polynomial results ride along as sideband.
    t_rot_side              w_rot_in, w_rot_out;
    logic                   w7_v;
    logic signed [SC_W-1:0] w7_x, w7_y;
    logic signed [Z_W-1:0]  w7_z;

    assign w_rot_in.quad  = r6_quad;
    assign w_rot_in.flag  = r6_f;
    assign w_rot_in.slope = r6_s;
    assign w_rot_in.y     = r6_y;

    cpsa_cordic #(
        .STEPS     (CORDIC_STEPS),
        .W         (SC_W),
        .SW        ($bits(t_rot_side)),
        .VECTORING (1'b0)
    ) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_v),
        .i_x     (INV_GAIN_Q30),
        .i_y     ('0),
        .i_z     (r6_z),
        .i_side  (w_rot_in),
        .o_valid (w7_v),
        .o_x     (w7_x),
        .o_y     (w7_y),
        .o_z     (w7_z),
        .o_side  (w_rot_out)
    );

    // Stage 8: quadrant fold.
    logic                   r8_v;
    t_rot_side              r8_side;
    logic signed [SC_W-1:0] r8_s, r8_c, w8_s, w8_c;

    always_comb begin
        unique case (w_rot_out.quad)
            2'd0: begin w8_s = w7_y;  w8_c = w7_x;  end
            2'd1: begin w8_s = w7_x;  w8_c = -w7_y; end
            2'd2: begin w8_s = -w7_y; w8_c = -w7_x; end
            2'd3: begin w8_s = -w7_x; w8_c = w7_y;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_side <= w_rot_out;
            r8_s    <= w8_s;
            r8_c    <= w8_c;
        end
    end

    // Stage 9: amplitude products.
    logic               r9_v;
    t_rot_side          r9_side;
    logic signed [65:0] r9_as, r9_ac;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_side <= r8_side;
            r9_as   <= r_c3 * r8_s;
            r9_ac   <= r_c3 * r8_c;
        end
    end

    // Stage 10: sinusoid value.
    logic               r10_v, r10_yf;
    t_rot_side          r10_side;
    logic signed [31:0] r10_y;
    logic signed [35:0] r10_u;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_side        <= r9_side;
            {r10_yf, r10_y} <= sat32(70'($signed(r9_as[65:30])) + 70'(r_c0));
            r10_u           <= $signed(r9_ac[65:30]);
        end
    end

    // Stage 11: slope product with the stretch.
    logic               r11_v, r11_yf;
    t_rot_side          r11_side;
    logic signed [31:0] r11_y;
    logic signed [67:0] r11_ub;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_side <= r10_side;
            r11_yf   <= r10_yf;
            r11_y    <= r10_y;
            r11_ub   <= r10_u * r_c2;
        end
    end

    // Stage 12: pick the curve result.
    logic               r12_v, r12_f;
    logic signed [31:0] r12_y, r12_s, w12_s;
    logic               w12_sf;

    always_comb begin
        {w12_sf, w12_s} = sat32(70'($signed(r11_ub[67:16])));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_kind == KIND_SINE) begin
                r12_y <= r11_y;
                r12_s <= w12_s;
                r12_f <= r11_yf | w12_sf;
            end else begin
                r12_y <= r11_side.y;
                r12_s <= r11_side.slope;
                r12_f <= r11_side.flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r12_v <= 1'b0;
        end else if (w_en) begin
            r8_v  <= w7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
            r11_v <= r10_v;
            r12_v <= r11_v;
        end
    end

    // atan CORDIC on the vector (1, slope).
    t_vec_side              w_vec_in, w_vec_out;
    logic                   w13_v;
    logic signed [HV_W-1:0] w13_x, w13_y;
    logic signed [Z_W-1:0]  w13_z;

    assign w_vec_in.flag = r12_f;
    assign w_vec_in.y    = r12_y;

    cpsa_cordic #(
        .STEPS     (CORDIC_STEPS),
        .W         (HV_W),
        .SW        ($bits(t_vec_side)),
        .VECTORING (1'b1)
    ) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r12_v),
        .i_x     (HV_W'(64'sd1073741824)),
        .i_y     (HV_W'(r12_s) <<< 14),
        .i_z     ('0),
        .i_side  (w_vec_in),
        .o_valid (w13_v),
        .o_x     (w13_x),
        .o_y     (w13_y),
        .o_z     (w13_z),
        .o_side  (w_vec_out)
    );

    // Stage 14: radians to degrees.
    logic               r14_v;
    t_vec_side          r14_side;
    logic signed [64:0] r14_dz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r14_side <= w_vec_out;
            r14_dz   <= w13_z * DEG_PER_RAD_Q24;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r14_v <= 1'b0;
        end else if (w_en) begin
            r14_v <= w13_v;
        end
    end

    // Output register with the heading clamp.
    logic signed [26:0] w_deg;
    logic signed [23:0] w_head;
    logic signed [31:0] r_out_y;
    logic signed [23:0] r_out_h;
    logic               r_out_f;

    assign w_deg = $signed(r14_dz[64:38]);

    always_comb begin
        priority if (w_deg > DEG90_Q16) begin
            w_head = DEG90_Q16[23:0];
        end else if (w_deg < -DEG90_Q16) begin
            w_head = 24'(-DEG90_Q16);
        end else begin
            w_head = w_deg[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r14_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_y <= r14_side.y;
            r_out_h <= w_head;
            r_out_f <= r14_side.flag;
        end
    end

    assign o_out_valid       = r_out_v;
    assign o_y_value         = r_out_y;
    assign o_heading_degrees = r_out_h;
    assign o_saturated       = r_out_f;

    // Unused CORDIC outputs are the atan residual vector and the sin/cos residual angle.
    logic w_unused;
    assign w_unused = ^{w13_x, w13_y, w7_z};

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_heading_degrees) <= 24'sd5898240 &&
                         $signed(o_heading_degrees) >= -24'sd5898240))
        else $error("heading outside plus or minus 90 degrees");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result presented right after reset");

    a_linear_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated && r_kind == KIND_LINEAR) |->
            (o_y_value == 32'sh7FFFFFFF || o_y_value == 32'sh80000000))
        else $error("linear curve flagged saturation without a clamped value");

endmodule
